// File: design/cbsp_pkg.sv
package cbsp_pkg;

  localparam int NumPointsDef = 6;
  localparam int Degree       = 3;
  localparam int Frac         = 24;
  localparam int CoordW       = 32;
  localparam int IdxW         = 4;
  localparam int BasisW       = Frac + 1;
  localparam int QW           = Frac + 2;
  localparam int DivShift     = QW + 2;
  localparam int M3           = (2 ** DivShift + 2) / 3;
  localparam int RegIdxW      = 2;

  localparam logic [RegIdxW-1:0] REG_KNOT_MIN = 2'd0;
  localparam logic [RegIdxW-1:0] REG_KNOT_MAX = 2'd1;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_EVAL  = 1'b1;

  typedef struct packed {
    logic                     mode;
    logic [IdxW-1:0]          point_index;
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
    logic signed [CoordW-1:0] t_value;
  } in_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] curve_x;
    logic signed [CoordW-1:0] curve_y;
    logic signed [CoordW-1:0] curve_z;
    logic                     in_range;
  } out_item_t;

  typedef struct packed {
    logic [RegIdxW-1:0] reg_index;
    logic [CoordW-1:0]  wr_data;
  } cfg_item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } point_t;

  typedef struct packed {
    logic            init;
    logic            ph_a;
    logic            ph_b;
    logic            ph_c;
    logic [1:0]      level;
    logic            rotate;
    logic            wr_en;
    logic [IdxW-1:0] wr_idx;
  } cell_ctl_t;

  // clamped knot position in whole segment units
  function automatic int knot_units(input int j, input int segs);
    int v;
    v = j - Degree;
    if (v < 0) v = 0;
    if (v > segs) v = segs;
    return v;
  endfunction

  // floor(v / d) for d in 1..3, zero for d of 0
  function automatic logic [QW-1:0] div_small(input logic [QW-1:0] v, input logic [1:0] d);
    logic [QW+DivShift-2:0] p;
    logic [QW-1:0]          r;
    p = v * (DivShift-1)'(M3);
    unique case (d)
      2'd1:    r = v;
      2'd2:    r = v >> 1;
      2'd3:    r = QW'(p >> DivShift);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// File: design/cbsp_chan_if.sv
interface cbsp_chan_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: design/cbsp_cell.sv
module cbsp_cell import cbsp_pkg::*; #(
  parameter int NumPoints = NumPointsDef,
  parameter int Idx       = 0,
  localparam int Segs     = NumPoints - Degree,
  localparam int SegW     = $clog2(Segs + 1),
  localparam int XW       = Frac + SegW
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_ctl_t         ctl_i,
  input  logic [XW-1:0]     x_i,
  input  point_t            wr_point_i,
  input  point_t            point_i,
  input  logic [BasisW-1:0] basis_i,
  output point_t            point_o,
  output logic [BasisW-1:0] basis_o
);

  localparam int ProdW = XW + BasisW;

  point_t            point_q, point_d;
  logic [BasisW-1:0] basis_q, basis_d;
  logic [ProdW-1:0]  prod_q, prod_d;
  logic [QW-1:0]     lq_q, lq_d;

  logic [SegW-1:0] k0, k1, kl, kr;
  logic [1:0]      dl, dr;
  logic [XW-1:0]   pos0, pos1, posr, dist_l, dist_r;

  always_comb begin
    k0 = SegW'(knot_units(Idx, Segs));
    k1 = SegW'(knot_units(Idx + 1, Segs));
    kl = SegW'(knot_units(Idx + int'(ctl_i.level), Segs));
    kr = SegW'(knot_units(Idx + int'(ctl_i.level) + 1, Segs));
    dl = 2'(kl - k0);
    dr = 2'(kr - k1);
    pos0 = {k0, {Frac{1'b0}}};
    pos1 = {k1, {Frac{1'b0}}};
    posr = {kr, {Frac{1'b0}}};
    dist_l = (x_i > pos0) ? x_i - pos0 : '0;
    dist_r = (posr > x_i) ? posr - x_i : '0;
  end

  always_comb begin
    point_d = point_q;
    basis_d = basis_q;
    prod_d  = prod_q;
    lq_d    = lq_q;
    if (ctl_i.wr_en && ctl_i.wr_idx == IdxW'(Idx)) begin
      point_d = wr_point_i;
    end
    if (ctl_i.rotate) begin
      point_d = point_i;
      basis_d = basis_i;
    end
    if (ctl_i.init) begin
      basis_d = (x_i > pos0 && x_i <= pos1) ? {1'b1, {Frac{1'b0}}} : '0;
    end
    // left term product, then its divide while the right product forms
    if (ctl_i.ph_a) begin
      prod_d = ProdW'(dist_l) * ProdW'(basis_q);
    end
    if (ctl_i.ph_b) begin
      lq_d   = div_small(prod_q[Frac +: QW], dl);
      prod_d = ProdW'(dist_r) * ProdW'(basis_i);
    end
    if (ctl_i.ph_c) begin
      basis_d = BasisW'(lq_q + div_small(prod_q[Frac +: QW], dr));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_q <= '0;
    end else begin
      point_q <= point_d;
    end
  end

  always_ff @(posedge clk_i) begin
    basis_q <= basis_d;
    prod_q  <= prod_d;
    lq_q    <= lq_d;
  end

  assign point_o = point_q;
  assign basis_o = basis_q;

endmodule

// File: design/cbsp_div.sv
module cbsp_div import cbsp_pkg::*; #(
  parameter int NumPoints = NumPointsDef,
  localparam int Segs     = NumPoints - Degree,
  localparam int SegW     = $clog2(Segs + 1),
  localparam int XW       = Frac + SegW,
  localparam int SpanW    = CoordW + 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [SpanW-1:0] off_i,
  input  logic [SpanW-1:0] span_i,
  output logic             done_o,
  output logic [XW-1:0]    quot_o
);

  localparam int PW   = SpanW + SegW;
  localparam int CntW = $clog2(XW + 1);

  logic [SpanW:0]   rem_q, rem_d;
  logic [XW-1:0]    dq_q, dq_d;
  logic [SpanW-1:0] den_q, den_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;

  logic [PW-1:0]  prod;
  logic [SpanW:0] trial;
  logic           ge;

  always_comb begin
    prod   = PW'(off_i) * PW'(Segs);
    trial  = {rem_q[SpanW-1:0], dq_q[XW-1]};
    ge     = trial >= {1'b0, den_q};
    rem_d  = rem_q;
    dq_d   = dq_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      // upper dividend bits sit below the divisor, so only XW quotient bits remain
      rem_d  = (SpanW+1)'(prod >> SegW);
      dq_d   = {prod[SegW-1:0], {Frac{1'b0}}};
      den_d  = span_i;
      cnt_d  = CntW'(XW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? trial - {1'b0, den_q} : trial;
      dq_d  = {dq_q[XW-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dq_q  <= dq_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = dq_q;

endmodule

// File: design/clamped_bspline_curve_eval_unit.sv
// store item: written into its control point when taken, no result
// evaluate item: result formed by the bit-serial knot division, three basis levels each in phases a, b, c
// and the point ring walk; out of range or at the start, the basis levels and the ring walk are skipped
// one item in flight at a time; the next item is taken while a result waits in the output register
// reset clears control state, knot_min to 0, knot_max to 1.0 and all control points to zero
module clamped_bspline_curve_eval_unit import cbsp_pkg::*; #(
  parameter int NumPoints = NumPointsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cbsp_chan_if.sink   in_i,
  cbsp_chan_if.sink   cfg_i,
  cbsp_chan_if.source res_o
);

  localparam int Segs  = NumPoints - Degree;
  localparam int SegW  = $clog2(Segs + 1);
  localparam int XW    = Frac + SegW;
  localparam int SpanW = CoordW + 1;
  localparam int MulW  = BasisW + 1 + CoordW;
  localparam int AccW  = MulW + $clog2(NumPoints);
  localparam int RcW   = $clog2(NumPoints + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DIV   = 6'b000010,
    S_INIT  = 6'b000100,
    S_BASIS = 6'b001000,
    S_MAC   = 6'b010000,
    S_FIN   = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic signed [CoordW-1:0] kmin_q, kmin_d, kmax_q, kmax_d;
  logic                     oor_q, oor_d, first_q, first_d, pv_q, pv_d;
  logic [XW-1:0]            x_q, x_d;
  logic [1:0]               lvl_q, lvl_d, ph_q, ph_d;
  logic [RcW-1:0]           rcnt_q, rcnt_d;
  logic                     out_vld_q, out_vld_d;
  out_item_t                out_q, out_d;
  logic signed [AccW-1:0]   acc_q [3];
  logic signed [AccW-1:0]   acc_d [3];
  logic signed [MulW-1:0]   mul_q [3];
  logic signed [MulW-1:0]   mul_d [3];

  point_t            cell_point [NumPoints];
  logic [BasisW-1:0] cell_basis [NumPoints];
  cell_ctl_t         ctl;
  logic              accept, oor, off_zero, div_start, div_done, load;
  logic [SpanW-1:0]  off, span;
  logic [XW-1:0]     quot;
  logic signed [CoordW-1:0] head_c [3];

  function automatic logic signed [CoordW-1:0] round_sat(input logic signed [AccW-1:0] a);
    logic [AccW-1:0]      v;
    logic [AccW-Frac-1:0] r;
    logic [CoordW-1:0]    s;
    v = a + {{(AccW-Frac){1'b0}}, 1'b1, {(Frac-1){1'b0}}};
    r = v[AccW-1:Frac];
    if ((&r[AccW-Frac-1:CoordW-1]) || !(|r[AccW-Frac-1:CoordW-1])) begin
      s = r[CoordW-1:0];
    end else begin
      s = r[AccW-Frac-1] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
    end
    return signed'(s);
  endfunction

  assign in_i.ready  = (state_q == S_IDLE);
  assign cfg_i.ready = 1'b1;
  assign accept      = in_i.valid && in_i.ready;

  always_comb begin
    oor       = (in_i.data.t_value < kmin_q) || (in_i.data.t_value > kmax_q);
    off       = {in_i.data.t_value[CoordW-1], in_i.data.t_value} - {kmin_q[CoordW-1], kmin_q};
    span      = {kmax_q[CoordW-1], kmax_q} - {kmin_q[CoordW-1], kmin_q};
    off_zero  = (off == '0);
    div_start = accept && in_i.data.mode == MODE_EVAL && !oor && !off_zero;
  end

  cbsp_div #(.NumPoints(NumPoints)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .off_i   (off),
    .span_i  (span),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  always_comb begin
    ctl.init   = (state_q == S_INIT);
    ctl.ph_a   = (state_q == S_BASIS) && ph_q == 2'd0;
    ctl.ph_b   = (state_q == S_BASIS) && ph_q == 2'd1;
    ctl.ph_c   = (state_q == S_BASIS) && ph_q == 2'd2;
    ctl.level  = lvl_q;
    ctl.rotate = (state_q == S_MAC) && rcnt_q < RcW'(NumPoints);
    ctl.wr_en  = accept && in_i.data.mode == MODE_WRITE;
    ctl.wr_idx = in_i.data.point_index;
  end

  for (genvar j = 0; j < NumPoints; j++) begin : g_cell
    localparam int Nb = (j + 1) % NumPoints;
    logic [BasisW-1:0] nb_basis;
    // the last cell sees a zero neighbor in the recursion and closes the ring when walking
    if (j == NumPoints - 1) begin : g_last
      assign nb_basis = ctl.rotate ? cell_basis[Nb] : '0;
    end else begin : g_mid
      assign nb_basis = cell_basis[Nb];
    end
    cbsp_cell #(.NumPoints(NumPoints), .Idx(j)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .x_i        (x_q),
      .wr_point_i ({in_i.data.point_x, in_i.data.point_y, in_i.data.point_z}),
      .point_i    (cell_point[Nb]),
      .basis_i    (nb_basis),
      .point_o    (cell_point[j]),
      .basis_o    (cell_basis[j])
    );
  end

  assign head_c[0] = cell_point[0].x;
  assign head_c[1] = cell_point[0].y;
  assign head_c[2] = cell_point[0].z;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mul_d[c] = $signed({1'b0, cell_basis[0]}) * head_c[c];
      acc_d[c] = acc_q[c];
      if (state_q == S_INIT) begin
        acc_d[c] = '0;
      end else if (pv_q) begin
        acc_d[c] = acc_q[c] + AccW'(mul_q[c]);
      end
    end
  end

  always_comb begin
    kmin_d = kmin_q;
    kmax_d = kmax_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.data.reg_index)
        REG_KNOT_MIN: kmin_d = signed'(cfg_i.data.wr_data);
        REG_KNOT_MAX: kmax_d = signed'(cfg_i.data.wr_data);
        default: ;
      endcase
    end
  end

  assign load = (state_q == S_FIN) && (!out_vld_q || res_o.ready);

  always_comb begin
    state_d   = state_q;
    oor_d     = oor_q;
    first_d   = first_q;
    x_d       = x_q;
    lvl_d     = lvl_q;
    ph_d      = ph_q;
    rcnt_d    = rcnt_q;
    pv_d      = 1'b0;
    out_d     = out_q;
    out_vld_d = out_vld_q && !res_o.ready;
    unique case (state_q)
      S_IDLE: begin
        if (accept && in_i.data.mode == MODE_EVAL) begin
          oor_d   = oor;
          first_d = !oor && off_zero;
          state_d = (oor || off_zero) ? S_FIN : S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          x_d = quot;
          if (quot == '0) begin
            first_d = 1'b1;
            state_d = S_FIN;
          end else begin
            state_d = S_INIT;
          end
        end
      end
      S_INIT: begin
        lvl_d   = 2'd1;
        ph_d    = 2'd0;
        state_d = S_BASIS;
      end
      S_BASIS: begin
        if (ph_q == 2'd2) begin
          ph_d = 2'd0;
          if (lvl_q == 2'(Degree)) begin
            rcnt_d  = '0;
            state_d = S_MAC;
          end else begin
            lvl_d = lvl_q + 2'd1;
          end
        end else begin
          ph_d = ph_q + 2'd1;
        end
      end
      S_MAC: begin
        // products of the last ring step pass through the product register before landing in the accumulator
        pv_d   = rcnt_q < RcW'(NumPoints);
        rcnt_d = rcnt_q + 1'b1;
        if (rcnt_q == RcW'(NumPoints)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (load) begin
          out_vld_d = 1'b1;
          if (oor_q) begin
            out_d = '0;
          end else if (first_q) begin
            out_d.curve_x  = cell_point[0].x;
            out_d.curve_y  = cell_point[0].y;
            out_d.curve_z  = cell_point[0].z;
            out_d.in_range = 1'b1;
          end else begin
            out_d.curve_x  = round_sat(acc_q[0]);
            out_d.curve_y  = round_sat(acc_q[1]);
            out_d.curve_z  = round_sat(acc_q[2]);
            out_d.in_range = 1'b1;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      kmin_q    <= '0;
      kmax_q    <= 32'sh0001_0000;
      oor_q     <= 1'b0;
      first_q   <= 1'b0;
      lvl_q     <= '0;
      ph_q      <= '0;
      rcnt_q    <= '0;
      pv_q      <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      kmin_q    <= kmin_d;
      kmax_q    <= kmax_d;
      oor_q     <= oor_d;
      first_q   <= first_d;
      lvl_q     <= lvl_d;
      ph_q      <= ph_d;
      rcnt_q    <= rcnt_d;
      pv_q      <= pv_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q   <= x_d;
    out_q <= out_d;
    for (int c = 0; c < 3; c++) begin
      mul_q[c] <= mul_d[c];
      acc_q[c] <= acc_d[c];
    end
  end

  assign res_o.valid = out_vld_q;
  assign res_o.data  = out_q;

`ifndef SYNTHESIS
  a_res_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !$past(out_vld_q)) |-> $past(state_q == S_FIN))
    else $error("result raised outside the finish state");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == S_DIV)
    else $error("division finished while not waiting for it");

  a_ring_restored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && $past(state_q) == S_MAC) |->
      cell_point[0] == $past(cell_point[0], NumPoints + 2))
    else $error("point ring not back in place after the walk");

  a_out_of_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_q.in_range) |->
      (out_q.curve_x == '0 && out_q.curve_y == '0 && out_q.curve_z == '0))
    else $error("out-of-range result carries a nonzero point");
`endif

endmodule

// File: tb/sv/tb_clamped_bspline_curve_eval_unit.sv
module tb_clamped_bspline_curve_eval_unit;
  import cbsp_pkg::*;

  localparam int NPts = NumPointsDef;
  localparam int Segs = NPts - Degree;
  localparam int NKnots = NPts + Degree + 1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cbsp_chan_if #(.data_t(in_item_t))  in_ch ();
  cbsp_chan_if #(.data_t(cfg_item_t)) cfg_ch ();
  cbsp_chan_if #(.data_t(out_item_t)) res_ch ();

  clamped_bspline_curve_eval_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .cfg_i  (cfg_ch),
    .res_o  (res_ch)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // shadow state of the curve unit
  longint    span_lo, span_hi;
  longint    ctrl_pts[NPts][3];
  in_item_t  pending_items[$];
  out_item_t expected_points[$];
  int        mismatches = 0;
  bit        stim_done = 1'b0;
  bit        sink_hold = 1'b0;
  // handshakes seen at the rising edge, picked up at the next falling edge
  int        in_taken = 0;
  int        in_seen = 0;
  int        res_taken = 0;
  int        res_seen = 0;

  function automatic void add_item(in_item_t it);
    pending_items = {pending_items, it};
  endfunction

  function automatic longint round_to_q16(longint v);
    longint r;
    v += longint'(1) << (Frac - 1);
    r = v >>> Frac;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r;
  endfunction

  function automatic int knot_at(int j);
    int v;
    v = j - Degree;
    if (v < 0) v = 0;
    if (v > Segs) v = Segs;
    return v;
  endfunction

  function automatic out_item_t eval_curve(longint tv);
    out_item_t o;
    longint off, span, xq, one, sum, dl, dr;
    longint bas[NKnots];
    longint acc[3];
    logic [63:0] pos;
    o = '0;
    if (tv < span_lo || tv > span_hi) return o;
    off = tv - span_lo;
    span = span_hi - span_lo;
    pos = '0;
    if (off > 0 && span > 0) pos = ((64'(off) * Segs) << Frac) / 64'(span);
    o.in_range = 1'b1;
    if (pos == 0) begin
      o.curve_x = 32'(ctrl_pts[0][0]);
      o.curve_y = 32'(ctrl_pts[0][1]);
      o.curve_z = 32'(ctrl_pts[0][2]);
      return o;
    end
    xq = longint'(pos);
    one = longint'(1) << Frac;
    for (int j = 0; j < NKnots - 1; j++)
      bas[j] = (knot_at(j) * one < xq && xq <= knot_at(j + 1) * one) ? one : 0;
    bas[NKnots - 1] = 0;
    for (int k = 1; k <= Degree; k++) begin
      for (int j = 0; j < NKnots - 1 - k; j++) begin
        sum = 0;
        dl = knot_at(j + k) - knot_at(j);
        dr = knot_at(j + k + 1) - knot_at(j + 1);
        if (dl != 0) sum += ((xq - knot_at(j) * one) * bas[j]) / (dl * one);
        if (dr != 0) sum += ((knot_at(j + k + 1) * one - xq) * bas[j + 1]) / (dr * one);
        bas[j] = sum;
      end
      bas[NKnots - 1 - k] = 0;
    end
    acc = '{0, 0, 0};
    for (int j = 0; j < NPts; j++)
      for (int c = 0; c < 3; c++) acc[c] += bas[j] * ctrl_pts[j][c];
    o.curve_x = 32'(round_to_q16(acc[0]));
    o.curve_y = 32'(round_to_q16(acc[1]));
    o.curve_z = 32'(round_to_q16(acc[2]));
    return o;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // input driver
  int src_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken != in_seen) begin
        in_seen = in_taken;
        void'(pending_items.pop_front());
        src_gap = pick_gap();
      end
      if (src_gap > 0) begin
        src_gap--;
        in_ch.valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_ch.valid <= 1'b1;
        in_ch.data  <= pending_items[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // predictor on accepted items
  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready) begin
      in_taken++;
      if (in_ch.data.mode == MODE_WRITE) begin
        if (in_ch.data.point_index < NPts) begin
          ctrl_pts[in_ch.data.point_index][0] = longint'(in_ch.data.point_x);
          ctrl_pts[in_ch.data.point_index][1] = longint'(in_ch.data.point_y);
          ctrl_pts[in_ch.data.point_index][2] = longint'(in_ch.data.point_z);
        end
      end else begin
        expected_points = {expected_points, eval_curve(longint'(in_ch.data.t_value))};
      end
    end
    if (rst_ni && cfg_ch.valid && cfg_ch.ready) begin
      if (cfg_ch.data.reg_index == REG_KNOT_MIN) span_lo = longint'(signed'(cfg_ch.data.wr_data));
      else if (cfg_ch.data.reg_index == REG_KNOT_MAX)
        span_hi = longint'(signed'(cfg_ch.data.wr_data));
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      res_taken++;
      if (expected_points.size() == 0) begin
        $error("unexpected result item %h", res_ch.data);
        mismatches++;
      end else begin
        want = expected_points.pop_front();
        if (res_ch.data.curve_x !== want.curve_x) begin
          $error("curve_x exp %0d got %0d", want.curve_x, res_ch.data.curve_x);
          mismatches++;
        end
        if (res_ch.data.curve_y !== want.curve_y) begin
          $error("curve_y exp %0d got %0d", want.curve_y, res_ch.data.curve_y);
          mismatches++;
        end
        if (res_ch.data.curve_z !== want.curve_z) begin
          $error("curve_z exp %0d got %0d", want.curve_z, res_ch.data.curve_z);
          mismatches++;
        end
        if (res_ch.data.in_range !== want.in_range) begin
          $error("in_range exp %0b got %0b", want.in_range, res_ch.data.in_range);
          mismatches++;
        end
      end
    end
  end

  // result receiver back-pressure
  int sink_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (res_taken != res_seen) begin
        res_seen = res_taken;
        sink_gap = pick_gap();
      end
      if (sink_hold) begin
        res_ch.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  function automatic logic [31:0] rand_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'h7fffffff;
    if (r == 1) return 32'h80000000;
    if (r < 5) return $urandom();
    return 32'($signed($urandom_range(0, 400000)) - 200000);
  endfunction

  function automatic in_item_t make_store(int idx, logic [31:0] px, logic [31:0] py,
                                          logic [31:0] pz);
    in_item_t it;
    it = '0;
    it.mode = MODE_WRITE;
    it.point_index = IdxW'(idx);
    it.point_x = px;
    it.point_y = py;
    it.point_z = pz;
    it.t_value = $urandom();
    return it;
  endfunction

  function automatic in_item_t make_eval(logic [31:0] tv);
    in_item_t it;
    it = '0;
    it.mode = MODE_EVAL;
    it.point_index = IdxW'($urandom());
    it.point_x = $urandom();
    it.point_y = $urandom();
    it.point_z = $urandom();
    it.t_value = tv;
    return it;
  endfunction

  function automatic logic [31:0] rand_param();
    longint lo, span;
    int r;
    lo = span_lo;
    span = span_hi - span_lo;
    r = $urandom_range(0, 19);
    if (r == 0) return 32'(span_lo);
    if (r == 1) return 32'(span_hi);
    if (r == 2) return 32'(span_lo - 1);
    if (r == 3) return 32'(span_hi + 1);
    if (r == 4) return $urandom();
    if (span <= 0) return 32'(span_lo);
    return 32'(lo + longint'({$urandom(), $urandom()} % 64'(span + 1)));
  endfunction

  task automatic drain();
    wait (pending_items.size() == 0 && expected_points.size() == 0);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [RegIdxW-1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= '{reg_index: idx, wr_data: val};
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_phase(logic [31:0] lo, logic [31:0] hi, int n);
    drain();
    write_reg(REG_KNOT_MIN, lo);
    write_reg(REG_KNOT_MAX, hi);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0)
        add_item(make_store($urandom_range(0, 15), rand_word(), rand_word(), rand_word()));
      else
        add_item(make_eval(rand_param()));
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    res_ch.ready = 1'b0;
    span_lo = 0;
    span_hi = 65536;
    for (int j = 0; j < NPts; j++) ctrl_pts[j] = '{0, 0, 0};
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: default range, zero points, extremes, unused index
    add_item(make_eval(32'd32768));
    add_item(make_eval(32'd0));
    add_item(make_store(0, 32'h7fffffff, 32'h80000000, 32'd65536));
    add_item(make_store(1, 32'h7fffffff, 32'h7fffffff, 32'h80000000));
    add_item(make_store(2, 32'h7fffffff, 32'h80000000, 32'h7fffffff));
    add_item(make_store(3, 32'h7fffffff, 32'h7fffffff, 32'h80000000));
    add_item(make_store(4, 32'h80000000, 32'h7fffffff, 32'h7fffffff));
    add_item(make_store(NPts - 1, 32'h7fffffff, 32'h80000000, 32'hffff0000));
    add_item(make_store(15, 32'h12345678, 32'h9abcdef0, 32'h0f0f0f0f));
    add_item(make_store(NPts, 32'h1, 32'h2, 32'h3));
    add_item(make_eval(32'd0));
    add_item(make_eval(32'd1));
    add_item(make_eval(32'd21845));
    add_item(make_eval(32'd32768));
    add_item(make_eval(32'd65535));
    add_item(make_eval(32'd65536));
    add_item(make_eval(32'd65537));
    add_item(make_eval(32'hffffffff));
    add_item(make_eval(32'h7fffffff));
    add_item(make_eval(32'h80000000));

    // long stall on results while items keep coming
    drain();
    sink_hold = 1'b1;
    for (int i = 0; i < 10; i++) add_item(make_eval(rand_param()));
    repeat (400) @(posedge clk_i);
    sink_hold = 1'b0;

    run_phase(32'h80000000, 32'h7fffffff, 120);
    run_phase(32'hfffe0000, 32'h00030000, 150);
    run_phase(32'd1000, 32'd1000, 25);
    run_phase(32'd5000, 32'd1000, 25);
    run_phase(32'h7ffffffe, 32'h7fffffff, 40);
    run_phase(32'h80000000, 32'h80000001, 40);
    run_phase(32'd0, 32'd65536, 150);
    run_phase(32'h00100000, 32'h00500000, 120);
    drain();
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
